// ----- rtl/core/mail_command_tokenizer_macros.svh -----
// Assertion helpers used by the tokenizer RTL.
`ifndef MAIL_COMMAND_TOKENIZER_MACROS_SVH
`define MAIL_COMMAND_TOKENIZER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MCT_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mail_command_tokenizer: check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MCT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mail_command_tokenizer: check failed");

`endif

// ----- rtl/core/mct_pkg.sv -----
`default_nettype none

package mct_pkg;

    localparam int unsigned DefMaxNestDepth = 15;
    localparam int unsigned CountMax        = 255;

    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChDquote    = 8'h22;
    localparam logic [7:0] ChLangle    = 8'h3C;
    localparam logic [7:0] ChRangle    = 8'h3E;
    localparam logic [7:0] ChColon     = 8'h3A;
    localparam logic [7:0] ChSpace     = 8'h20;
    localparam logic [7:0] ChTab       = 8'h09;
    localparam logic [7:0] ChCr        = 8'h0D;

    localparam logic ModeByte = 1'b0;
    localparam logic ModeEnd  = 1'b1;

    // Progress of the "to:" / "from:" keyword match, one-hot.
    typedef enum logic [7:0] {
        PM_START = 8'b0000_0001,
        PM_T     = 8'b0000_0010,
        PM_TO    = 8'b0000_0100,
        PM_F     = 8'b0000_1000,
        PM_FR    = 8'b0001_0000,
        PM_FRO   = 8'b0010_0000,
        PM_FROM  = 8'b0100_0000,
        PM_DEAD  = 8'b1000_0000
    } prefix_t;

    typedef struct packed {
        logic    token_open;
        logic    quote_active;
        logic    dquote_on_top;
        logic    escape_pending;
        logic    error_mark;
        prefix_t prefix;
        logic [7:0] closed_tokens;
    } tok_state_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       keep;
        logic       token_end;
        logic       token_error;
        logic [7:0] token_count;
        logic       command_done;
    } tok_result_t;

    localparam tok_state_t StateReset = '{
        token_open:     1'b0,
        quote_active:   1'b0,
        dquote_on_top:  1'b0,
        escape_pending: 1'b0,
        error_mark:     1'b0,
        prefix:         PM_START,
        closed_tokens:  8'd0
    };

    function automatic prefix_t next_prefix(input prefix_t s, input logic [7:0] c);
        logic [7:0] lc;
        prefix_t    n;
        lc = (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
        n  = PM_DEAD;
        case (s)
            PM_START:
            begin
                if (lc == 8'h74)
                    n = PM_T;
                else if (lc == 8'h66)
                    n = PM_F;
            end
            PM_T:   if (lc == 8'h6F) n = PM_TO;
            PM_F:   if (lc == 8'h72) n = PM_FR;
            PM_FR:  if (lc == 8'h6F) n = PM_FRO;
            PM_FRO: if (lc == 8'h6D) n = PM_FROM;
            default: n = PM_DEAD;
        endcase
        return n;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {ChSpace, [ChTab:ChCr]};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mail_command_tokenizer.sv -----
// Mail command tokenizer.
// Input stream: one transaction per command byte (tuser = 0, byte in tdata) or
// one end-of-command marker (tuser = 1). Output stream: exactly one transaction
// per input transaction, in order, carrying the byte when it belongs to a
// token, the keep / token_end / token_error flags, the running token count and
// tlast on the result of the end-of-command marker.
// The result is registered: a byte accepted at one edge has its result valid after
// that edge. The whole per-byte state update and the result are computed
// combinationally from the tokenizer state registers, so throughput is one byte
// per cycle while the receiver does not stall.
// The result register doubles as the decoupling stage: a new byte is taken
// whenever the result register is empty or is being read in the same cycle.
// When the receiver stalls, the held result stays stable and input stalls
// after it.
// Reset clears the tokenizer state, the token count and the output valid.
// Angle bracket nesting saturates at MAX_NEST_DEPTH and marks the token bad.
`default_nettype none

module mail_command_tokenizer #(
    parameter int unsigned MAX_NEST_DEPTH = mct_pkg::DefMaxNestDepth
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  wire logic        s_axis_tuser,   // [0] mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] out_char, [15:8] token_count
    output logic [2:0]       m_axis_tuser,   // [0] keep, [1] token_end, [2] token_error
    output logic             m_axis_tlast    // command_done
);
    import mct_pkg::*;

    `include "mail_command_tokenizer_macros.svh"

    localparam int unsigned DEPTH_W = $clog2(MAX_NEST_DEPTH + 1);

    tok_state_t         state_reg, state_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    tok_result_t        result_reg, result_next;
    logic               valid_reg;
    logic               accept;

    assign s_axis_tready = !valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    mct_step #(
        .MAX_NEST_DEPTH (MAX_NEST_DEPTH),
        .DEPTH_W        (DEPTH_W)
    ) u_step (
        .state      (state_reg),
        .depth      (depth_reg),
        .mode       (s_axis_tuser),
        .ch         (s_axis_tdata),
        .state_next (state_next),
        .depth_next (depth_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StateReset;
            depth_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
                depth_reg <= depth_next;
            end
            if (accept)
                valid_reg <= 1'b1;
            else if (m_axis_tready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {result_reg.token_count, result_reg.out_char};
    assign m_axis_tuser  = {result_reg.token_error, result_reg.token_end, result_reg.keep};
    assign m_axis_tlast  = result_reg.command_done;

    `MCT_ASSERT_IMP(a_depth_bounded, 1'b1, depth_reg <= DEPTH_W'(MAX_NEST_DEPTH))
    `MCT_ASSERT_IMP(a_error_needs_end, m_axis_tvalid && m_axis_tuser[2], m_axis_tuser[1])
    `MCT_ASSERT_IMP(a_done_no_keep, m_axis_tvalid && m_axis_tlast, !m_axis_tuser[0])
    `MCT_ASSERT_NEXT(a_end_clears, accept && (s_axis_tuser == ModeEnd),
                     state_reg == StateReset && depth_reg == '0)

endmodule

`default_nettype wire

// ----- rtl/core/mct_step.sv -----
`default_nettype none

module mct_step #(
    parameter int unsigned MAX_NEST_DEPTH = mct_pkg::DefMaxNestDepth,
    parameter int unsigned DEPTH_W        = $clog2(MAX_NEST_DEPTH + 1)
) (
    input  wire mct_pkg::tok_state_t  state,
    input  wire logic [DEPTH_W-1:0]   depth,
    input  wire logic                 mode,
    input  wire logic [7:0]           ch,
    output mct_pkg::tok_state_t       state_next,
    output logic [DEPTH_W-1:0]        depth_next,
    output mct_pkg::tok_result_t      result
);
    import mct_pkg::*;

    localparam logic [DEPTH_W-1:0] DepthMax = DEPTH_W'(MAX_NEST_DEPTH);
    localparam logic [DEPTH_W-1:0] DepthOne = DEPTH_W'(1);

    tok_state_t        s;
    logic [DEPTH_W-1:0] d;
    logic              keep;
    logic              close;
    logic              err;
    logic              in_protected;
    logic [7:0]        count_inc;

    always_comb
    begin
        s     = state;
        d     = depth;
        keep  = 1'b0;
        close = 1'b0;
        in_protected = state.quote_active || (depth != '0);

        if (mode == ModeEnd)
        begin
            close = state.token_open;
        end
        else if (in_protected)
        begin
            keep     = 1'b1;
            s.prefix = PM_DEAD;
            if (state.escape_pending)
                s.escape_pending = 1'b0;
            else if (ch == ChBackslash)
                s.escape_pending = 1'b1;
            else if (state.quote_active || state.dquote_on_top)
            begin
                if (ch == ChDquote)
                begin
                    if (state.quote_active)
                        s.quote_active = 1'b0;
                    else
                        s.dquote_on_top = 1'b0;
                end
            end
            else if (ch == ChRangle)
                d = depth - DepthOne;
            else if (ch == ChDquote)
                s.dquote_on_top = 1'b1;
            else if (ch == ChLangle)
            begin
                if (depth < DepthMax)
                    d = depth + DepthOne;
                else
                    s.error_mark = 1'b1;
            end
        end
        else if (state.escape_pending)
        begin
            keep             = 1'b1;
            s.escape_pending = 1'b0;
            s.prefix         = PM_DEAD;
        end
        else if (is_space(ch))
        begin
            close = state.token_open;
        end
        else
        begin
            keep         = 1'b1;
            s.token_open = 1'b1;
            if (ch == ChLangle)
            begin
                d        = DepthOne;
                s.prefix = PM_DEAD;
            end
            else if (ch == ChDquote)
            begin
                s.quote_active = 1'b1;
                s.prefix       = PM_DEAD;
            end
            else if (ch == ChBackslash)
            begin
                s.escape_pending = 1'b1;
                s.prefix         = PM_DEAD;
            end
            else if (ch == ChColon)
            begin
                if (state.prefix == PM_TO || state.prefix == PM_FROM)
                    close = 1'b1;
                else
                    s.prefix = PM_DEAD;
            end
            else
                s.prefix = next_prefix(state.prefix, ch);
        end

        // The error check looks at the state as it stood before this byte.
        err = state.error_mark || state.quote_active || (depth != '0) ||
              state.dquote_on_top;

        count_inc = (state.closed_tokens < 8'(CountMax)) ?
                    state.closed_tokens + 8'd1 : state.closed_tokens;

        if (close)
        begin
            s               = StateReset;
            s.closed_tokens = count_inc;
            d               = '0;
        end

        result.out_char     = keep ? ch : 8'd0;
        result.keep         = keep;
        result.token_end    = close;
        result.token_error  = close && err;
        result.token_count  = s.closed_tokens;
        result.command_done = (mode == ModeEnd);

        // The end of a command returns everything to the reset state.
        if (mode == ModeEnd)
        begin
            s = StateReset;
            d = '0;
        end

        state_next = s;
        depth_next = d;
    end

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mct_pkg::*;

    localparam int unsigned NestLimit   = DefMaxNestDepth;
    localparam int          HoldCycles  = 60;
    localparam int          RandomItems = 1120;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    mail_command_tokenizer #(
        .MAX_NEST_DEPTH(NestLimit)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Tokenizer state as the checker sees it.
    logic        tk_open;
    logic        tk_quote;
    logic        tk_inner_quote;
    logic        tk_escape;
    logic        tk_bad;
    int unsigned tk_depth;
    prefix_t     tk_match;
    logic [7:0]  tk_count;

    tok_result_t pending_results[$];
    tok_result_t oldest;
    int          errors       = 0;
    int          items_sent   = 0;
    bit          tx_throttle  = 1'b1;
    bit          rx_throttle  = 1'b1;
    bit          hold_off_req = 1'b0;

    typedef enum int {
        PIECE_WORD,
        PIECE_KEYWORD,
        PIECE_QUOTED,
        PIECE_ANGLE,
        PIECE_ESCAPE,
        PIECE_NOISE
    } piece_t;

    function automatic prefix_t keyword_step(input prefix_t s, input logic [7:0] c);
        logic [7:0] lc;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        case (s)
            PM_START:
            begin
                if (lc == "t")
                    return PM_T;
                if (lc == "f")
                    return PM_F;
            end
            PM_T:   if (lc == "o") return PM_TO;
            PM_F:   if (lc == "r") return PM_FR;
            PM_FR:  if (lc == "o") return PM_FRO;
            PM_FRO: if (lc == "m") return PM_FROM;
            default: ;
        endcase
        return PM_DEAD;
    endfunction

    function automatic void clear_token_state();
        tk_open        = 1'b0;
        tk_quote       = 1'b0;
        tk_inner_quote = 1'b0;
        tk_escape      = 1'b0;
        tk_bad         = 1'b0;
        tk_depth       = 0;
        tk_match       = PM_START;
    endfunction

    // Closes the current token and tells whether it was malformed.
    function automatic logic close_token_state();
        logic bad;
        bad = tk_bad || tk_quote || tk_depth != 0 || tk_inner_quote;
        if (tk_count != 8'(CountMax))
            tk_count = tk_count + 8'd1;
        clear_token_state();
        return bad;
    endfunction

    function automatic tok_result_t tokenize_step(input logic mode, input logic [7:0] c);
        tok_result_t r;
        logic        bad;
        r   = '0;
        bad = 1'b0;
        if (mode == ModeEnd)
        begin
            if (tk_open)
            begin
                r.token_end = 1'b1;
                bad = close_token_state();
            end
            r.command_done = 1'b1;
        end
        else if (tk_quote || tk_depth != 0)
        begin
            r.keep   = 1'b1;
            tk_match = PM_DEAD;
            if (tk_escape)
                tk_escape = 1'b0;
            else if (c == ChBackslash)
                tk_escape = 1'b1;
            else if (tk_quote || tk_inner_quote)
            begin
                if (c == ChDquote)
                begin
                    if (tk_quote)
                        tk_quote = 1'b0;
                    else
                        tk_inner_quote = 1'b0;
                end
            end
            else if (c == ChRangle)
                tk_depth--;
            else if (c == ChDquote)
                tk_inner_quote = 1'b1;
            else if (c == ChLangle)
            begin
                if (tk_depth < NestLimit)
                    tk_depth++;
                else
                    tk_bad = 1'b1;
            end
        end
        else if (tk_escape)
        begin
            r.keep    = 1'b1;
            tk_escape = 1'b0;
            tk_match  = PM_DEAD;
        end
        else if (c inside {[8'h09:8'h0D], 8'h20})
        begin
            if (tk_open)
            begin
                r.token_end = 1'b1;
                bad = close_token_state();
            end
        end
        else
        begin
            r.keep  = 1'b1;
            tk_open = 1'b1;
            if (c == ChLangle)
            begin
                tk_depth = 1;
                tk_match = PM_DEAD;
            end
            else if (c == ChDquote)
            begin
                tk_quote = 1'b1;
                tk_match = PM_DEAD;
            end
            else if (c == ChBackslash)
            begin
                tk_escape = 1'b1;
                tk_match  = PM_DEAD;
            end
            else if (c == ChColon)
            begin
                // The colon stays in the keyword token and closes it.
                if (tk_match == PM_TO || tk_match == PM_FROM)
                begin
                    r.token_end = 1'b1;
                    bad = close_token_state();
                end
                else
                    tk_match = PM_DEAD;
            end
            else
                tk_match = keyword_step(tk_match, c);
        end
        r.token_count = tk_count;
        r.token_error = r.token_end && bad;
        r.out_char    = r.keep ? c : 8'h00;
        if (r.command_done)
        begin
            clear_token_state();
            tk_count = 8'd0;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // Results are checked before the input of the same edge is predicted, so one
    // process keeps the order right.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transaction with no expected result pending");
                    errors++;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    check_field("out_char", oldest.out_char, m_axis_tdata[7:0]);
                    check_field("token_count", oldest.token_count, m_axis_tdata[15:8]);
                    check_field("keep", oldest.keep, m_axis_tuser[0]);
                    check_field("token_end", oldest.token_end, m_axis_tuser[1]);
                    check_field("token_error", oldest.token_error, m_axis_tuser[2]);
                    check_field("command_done", oldest.command_done, m_axis_tlast);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(tokenize_step(s_axis_tuser, s_axis_tdata));
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 6);
    endfunction

    initial
    begin : receiver
        int unsigned stall;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HoldCycles - 1) @(negedge clk);
            end
            else if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(150) == 0)
                    rx_throttle = !rx_throttle;
                stall = rx_throttle ? pick_gap() : 0;
            end
        end
    end

    task automatic send_item(input logic mode, input logic [7:0] c);
        int unsigned gap;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= c;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
        gap = tx_throttle ? pick_gap() : 0;
        if (gap != 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic put(input logic [7:0] c);
        send_item(ModeByte, c);
    endtask

    task automatic end_command();
        send_item(ModeEnd, 8'($urandom_range(255)));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(8'hFF, 8'h21));
        while (c inside {ChLangle, ChDquote, ChBackslash, ChColon});
        return c;
    endfunction

    function automatic logic [7:0] blank_byte();
        logic [7:0] blanks[6];
        blanks = '{ChSpace, ChTab, 8'h0A, 8'h0B, 8'h0C, ChCr};
        return blanks[$urandom_range(5)];
    endfunction

    task automatic put_separator();
        if ($urandom_range(9) != 0)
            repeat ($urandom_range(3, 1)) put(blank_byte());
    endtask

    task automatic put_word();
        string hint;
        hint = "tofrmTOFRM:";
        repeat ($urandom_range(8, 1))
        begin
            if ($urandom_range(9) < 7)
                put(plain_byte());
            else
                put(hint[$urandom_range(hint.len() - 1)]);
        end
    endtask

    task automatic put_quoted();
        put(ChDquote);
        repeat ($urandom_range(8))
        begin
            case ($urandom_range(5))
                0: put(blank_byte());
                1: put(ChLangle);
                2: put(ChRangle);
                3:
                begin
                    put(ChBackslash);
                    put(8'($urandom_range(255)));
                end
                default: put(plain_byte());
            endcase
        end
        if ($urandom_range(9) != 0)
            put(ChDquote);
    endtask

    task automatic put_angle();
        int unsigned level;
        level = 1;
        put(ChLangle);
        repeat ($urandom_range(12, 1))
        begin
            case ($urandom_range(9))
                0: put(blank_byte());
                1:
                begin
                    put(ChLangle);
                    level++;
                end
                2:
                begin
                    if (level > 1)
                    begin
                        put(ChRangle);
                        level--;
                    end
                end
                3:
                begin
                    put(ChDquote);
                    repeat ($urandom_range(3)) put(plain_byte());
                    if ($urandom_range(1))
                        put(ChRangle);
                    put(ChDquote);
                end
                4:
                begin
                    put(ChBackslash);
                    put(8'($urandom_range(255)));
                end
                default: put(plain_byte());
            endcase
        end
        if ($urandom_range(9) != 0)
            repeat (level) put(ChRangle);
    endtask

    task automatic put_keyword();
        string word;
        if ($urandom_range(1))
            word = "to";
        else
            word = "from";
        for (int i = 0; i < word.len(); i++)
            put($urandom_range(1) ? word[i] - 8'h20 : word[i]);
        if ($urandom_range(9) != 0)
            put(ChColon);
        if ($urandom_range(1))
            put_angle();
    endtask

    task automatic send_command();
        piece_t piece;
        int unsigned r;
        if ($urandom_range(4) == 0)
            put_separator();
        repeat ($urandom_range(8))
        begin
            r = $urandom_range(99);
            piece = r < 30 ? PIECE_WORD : r < 45 ? PIECE_KEYWORD : r < 60 ? PIECE_QUOTED :
                    r < 78 ? PIECE_ANGLE : r < 88 ? PIECE_ESCAPE : PIECE_NOISE;
            case (piece)
                PIECE_WORD:    put_word();
                PIECE_KEYWORD: put_keyword();
                PIECE_QUOTED:  put_quoted();
                PIECE_ANGLE:   put_angle();
                PIECE_ESCAPE:
                begin
                    put(ChBackslash);
                    put(8'($urandom_range(255)));
                end
                default:       repeat ($urandom_range(6, 1)) put(8'($urandom_range(255)));
            endcase
            put_separator();
        end
        if ($urandom_range(9) == 0)
            put(ChBackslash);
        end_command();
    endtask

    task automatic test_directed();
        end_command();
        // Zero and all-ones bytes are ordinary token bytes.
        put(8'h00);
        put(8'hFF);
        put(ChSpace);
        put("T");
        put("o");
        put(ChColon);
        end_command();
        // An escaped blank at top level stays inside the token.
        put(ChBackslash);
        put(ChSpace);
        put("x");
        end_command();
        put(ChBackslash);
        end_command();
        put(ChDquote);
        put(ChBackslash);
        end_command();
        put(ChLangle);
        put(ChDquote);
        put(ChRangle);
        put(ChDquote);
        put(ChRangle);
        put(ChTab);
        end_command();
        wait_drained();
    endtask

    task automatic test_nesting();
        repeat (NestLimit) put(ChLangle);
        put("y");
        repeat (NestLimit) put(ChRangle);
        put(ChSpace);
        repeat (NestLimit + 1) put(ChLangle);
        put("z");
        repeat (NestLimit) put(ChRangle);
        end_command();
        put(ChLangle);
        put(ChBackslash);
        end_command();
        wait_drained();
    endtask

    task automatic test_count_saturation();
        repeat (CountMax + 5)
        begin
            put(plain_byte());
            put(blank_byte());
        end
        put("F");
        put("r");
        put("O");
        put("m");
        put(ChColon);
        end_command();
        wait_drained();
    endtask

    task automatic test_backpressure();
        tx_throttle  = 1'b0;
        hold_off_req = 1'b1;
        repeat (20)
        begin
            put_word();
            put(ChSpace);
        end
        end_command();
        wait_drained();
        tx_throttle = 1'b1;
    endtask

    task automatic test_random();
        int stop_at;
        stop_at = items_sent + RandomItems;
        while (items_sent < stop_at)
        begin
            tx_throttle = ($urandom_range(3) != 0);
            send_command();
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = ModeByte;
        m_axis_tready = 1'b0;
        clear_token_state();
        tk_count = 8'd0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_nesting();
        test_count_saturation();
        test_backpressure();
        test_random();
        repeat (5) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/mct_pkg.sv
rtl/core/mct_step.sv
rtl/core/mail_command_tokenizer.sv
verif/tb.sv
